### design/formation_setpoint_generator_macros.svh
// Assertion helpers shared by fsg_front and fsg_back.
`ifndef FORMATION_SETPOINT_GENERATOR_MACROS_SVH
`define FORMATION_SETPOINT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fsg_pkg.sv
package fsg_pkg;

  // Sine table: power of two depth, folded to one quarter wave.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam int QTR_IDX_W = SINE_IDX_W - 2;
  localparam int MAG_W = 19;

  localparam logic [23:0] CIRCLE_STEP = 24'd133509;
  localparam logic [23:0] ONE_THIRD = 24'd5592405;
  localparam logic [23:0] TWO_THIRDS = 24'd11184811;
  localparam logic [23:0] QUARTER_TURN = 24'h400000;

  localparam logic signed [31:0] HOVER_Z = 32'shFFF8_0000;
  localparam logic [15:0] START_TICK = 16'd50;
  localparam logic [15:0] CMD_TICK = 16'd20;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [11:0] ALPHA_Q16 = 12'd3277;

  // Input item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_MODE = 2'd1;
  localparam logic [1:0] KIND_POINT = 2'd2;

  // Result kinds
  localparam logic [1:0] RK_SETPOINT = 2'd0;
  localparam logic [1:0] RK_OFFBOARD = 2'd1;
  localparam logic [1:0] RK_ARM = 2'd2;

  // Formation modes
  localparam logic [7:0] MODE_CIRCLE = 8'd1;
  localparam logic [7:0] MODE_VEE = 8'd2;
  localparam logic [7:0] MODE_LINE = 8'd3;
  localparam logic [7:0] MODE_EXT = 8'd4;

  // Register index carried by paddr[2]
  localparam logic REG_VEHICLE_ID = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mode;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } fsg_item_t;

  // 4 m * sin(pi/2 * j/QTR_DEPTH) in Q16.16, from a Q30 odd polynomial.
  function automatic logic [MAG_W-1:0] qsine_mag(input int j);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] m;
    u = (64'(j) << 30) / QTR_DEPTH;
    u2 = (u * u) >> 30;
    p = 64'd172272;
    p = 64'd5026995 - ((u2 * p) >> 30);
    p = 64'd85569306 - ((u2 * p) >> 30);
    p = 64'd693598668 - ((u2 * p) >> 30);
    p = 64'd1686629713 - ((u2 * p) >> 30);
    m = (((u * p) >> 30) + 64'd2048) >> 12;
    return m[MAG_W-1:0];
  endfunction

endpackage

### design/fsg_circle.sv
module fsg_circle import fsg_pkg::*; (
  input  logic [23:0]        angle,
  output logic signed [31:0] value
);

  localparam logic [QTR_IDX_W:0] QTR_FULL = (QTR_IDX_W + 1)'(QTR_DEPTH);

  logic [MAG_W-1:0] qtab [0:QTR_DEPTH];
  logic [SINE_IDX_W-1:0] k;
  logic [1:0] quad;
  logic [QTR_IDX_W:0] r;
  logic [QTR_IDX_W:0] j;
  logic [31:0] m;

  for (genvar g = 0; g <= QTR_DEPTH; g++) begin : g_tab
    assign qtab[g] = qsine_mag(g);
  end

  assign k = angle[23 -: SINE_IDX_W];
  assign quad = k[SINE_IDX_W-1 -: 2];
  assign r = {1'b0, k[QTR_IDX_W-1:0]};
  // mirror the odd quadrants
  assign j = quad[0] ? (QTR_FULL - r) : r;
  assign m = 32'(qtab[j]);
  assign value = quad[1] ? -$signed(m) : $signed(m);

endmodule

### design/fsg_front.sv
`include "formation_setpoint_generator_macros.svh"

module fsg_front import fsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         kind,
  input  logic [7:0]         mode_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output fsg_item_t          head,
  output logic               head_valid,
  input  logic               head_pop
);

  fsg_item_t mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic known;
  logic push;

  assign item_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  // drop undefined kinds at the door
  assign known = (kind == KIND_TICK) || (kind == KIND_MODE) || (kind == KIND_POINT);
  assign push = item_valid && item_ready && known;
  assign head = mem[rd_ptr];
  assign head_valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{kind: kind, mode: mode_value, px: point_x, py: point_y,
                       pz: point_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (head_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, head_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `FSG_ASSERT_IMP(a_no_pop_empty, head_pop, count != '0, "pop from empty queue")
  `FSG_ASSERT_IMP(a_count_range, 1'b1, count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overrun")

endmodule

### design/fsg_back.sv
`include "formation_setpoint_generator_macros.svh"

module fsg_back import fsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fsg_item_t          head,
  input  logic               head_valid,
  output logic               head_pop,
  input  logic [6:0]         vehicle_id,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         result_kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_UPD = 3'd2;
  localparam logic [2:0] S_OFFB = 3'd3;
  localparam logic [2:0] S_ARM = 3'd4;

  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] w;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    w = 3'(t[2]) + 3'(t[1:0]);
    if (w >= 3'd3) begin
      w = w - 3'd3;
    end
    return w[1:0];
  endfunction

  logic [2:0] state;
  logic [15:0] tick_count;
  logic [7:0] active_mode;
  logic [23:0] circle_phase;
  logic signed [31:0] ext_target [3];
  logic signed [31:0] pos [3];

  logic d_neg [3];
  logic [32:0] mag [3];
  logic [44:0] prod [3];

  logic [23:0] phase_adv;
  logic [23:0] offset;
  logic [23:0] ang;
  logic [23:0] cos_ang;
  logic signed [31:0] cos_val;
  logic signed [31:0] sin_val;
  logic signed [31:0] half;
  logic signed [31:0] slot_y;
  logic run;
  logic signed [31:0] tgt [3];
  logic [32:0] diff [3];
  logic [32:0] mag_c [3];
  logic [44:0] rounded [3];
  logic [31:0] step [3];
  logic signed [31:0] pos_new [3];
  logic can_load;
  logic load;
  logic cmds;

  assign phase_adv = circle_phase + CIRCLE_STEP;
  assign ang = phase_adv + offset;
  assign cos_ang = ang + QUARTER_TURN;
  assign run = tick_count > START_TICK;
  assign half = $signed({9'b0, vehicle_id[6:1], 17'b0});
  assign can_load = !result_valid || result_ready;
  assign load = can_load && (state == S_UPD || state == S_OFFB || state == S_ARM);
  assign cmds = (tick_count == CMD_TICK);
  assign head_pop = (state == S_IDLE) && head_valid;

  fsg_circle u_cos (.angle(cos_ang), .value(cos_val));
  fsg_circle u_sin (.angle(ang), .value(sin_val));

  always_comb begin
    case (mod3({1'b0, vehicle_id} + 8'd2))
      2'd1: offset = ONE_THIRD;
      2'd2: offset = TWO_THIRDS;
      default: offset = '0;
    endcase
    if (vehicle_id == 7'd1) begin
      slot_y = '0;
    end else begin
      slot_y = vehicle_id[0] ? -half : half;
    end
    tgt[0] = '0;
    tgt[1] = '0;
    tgt[2] = HOVER_Z;
    if (run) begin
      case (active_mode)
        MODE_CIRCLE: begin
          tgt[0] = cos_val;
          tgt[1] = sin_val;
        end
        MODE_VEE: begin
          tgt[0] = (vehicle_id == 7'd1) ? 32'sd0 : -half;
          tgt[1] = slot_y;
        end
        MODE_LINE: begin
          tgt[1] = slot_y;
        end
        MODE_EXT: begin
          tgt[0] = ext_target[0];
          tgt[1] = ext_target[1];
          tgt[2] = ext_target[2];
        end
        default: begin
          tgt[0] = '0;
        end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      diff[i] = {tgt[i][31], tgt[i]} - {pos[i][31], pos[i]};
      mag_c[i] = diff[i][32] ? -diff[i] : diff[i];
      // round half up in magnitude, then apply the sign of the difference
      rounded[i] = prod[i] + 45'd32768;
      step[i] = 32'(rounded[i][44:16]);
      pos_new[i] = d_neg[i] ? pos[i] - $signed(step[i]) : pos[i] + $signed(step[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && head_valid && head.kind == KIND_TICK) begin
      for (int i = 0; i < 3; i++) begin
        d_neg[i] <= diff[i][32];
        mag[i] <= mag_c[i];
      end
    end
    if (state == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= 45'(mag[i]) * 45'(ALPHA_Q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick_count <= '0;
      active_mode <= '0;
      circle_phase <= '0;
      ext_target[0] <= '0;
      ext_target[1] <= '0;
      ext_target[2] <= HOVER_Z;
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= HOVER_Z;
      result_valid <= 1'b0;
    end else begin
      result_valid <= load || (result_valid && !result_ready);
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            case (head.kind)
              KIND_MODE: active_mode <= head.mode;
              KIND_POINT: begin
                ext_target[0] <= head.px;
                ext_target[1] <= head.py;
                ext_target[2] <= head.pz;
              end
              default: begin
                if (run) begin
                  circle_phase <= phase_adv;
                end
                state <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: state <= S_UPD;
        S_UPD: begin
          if (can_load) begin
            for (int i = 0; i < 3; i++) begin
              pos[i] <= pos_new[i];
            end
            result_kind <= RK_SETPOINT;
            out_x <= pos_new[0];
            out_y <= pos_new[1];
            out_z <= pos_new[2];
            last <= !cmds;
            if (tick_count != TICK_MAX) begin
              tick_count <= tick_count + 1'b1;
            end
            state <= cmds ? S_OFFB : S_IDLE;
          end
        end
        S_OFFB: begin
          if (can_load) begin
            result_kind <= RK_OFFBOARD;
            out_x <= '0;
            out_y <= '0;
            out_z <= '0;
            last <= 1'b0;
            state <= S_ARM;
          end
        end
        S_ARM: begin
          if (can_load) begin
            result_kind <= RK_ARM;
            out_x <= '0;
            out_y <= '0;
            out_z <= '0;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FSG_ASSERT_NXT(a_cmd_follows, state == S_UPD && can_load && cmds, state == S_OFFB, "command tick lost its commands")
  `FSG_ASSERT_IMP(a_cmd_zero, result_valid && result_kind != RK_SETPOINT, out_x == 0 && out_y == 0 && out_z == 0, "command carries coordinates")
  `FSG_ASSERT_NXT(a_tick_mono, 1'b1, tick_count >= $past(tick_count), "tick count went backward")

endmodule

### design/formation_setpoint_generator.sv
// Position setpoint generator for one vehicle of a formation.
// Input channel (item_valid/item_ready): kind 0 is a 100 ms tick, kind 1 a
// mode command (mode_value), kind 2 an external target point (point_x/y/z,
// Q16.16 m). Kind 3 is accepted and dropped. Items go into a 4-entry queue
// and are executed in order, so a mode or point applies from the next tick.
// Output channel (result_valid/result_ready): each tick yields one setpoint
// (result_kind 0) with last high; tick number 20 also yields a set-offboard
// and an arm command, last high only on the arm.
// The execution sequencer steps each tick through target lookup, multiply
// and update, adds the set-offboard and arm steps on the command tick, and
// applies a mode or point item while idle. The queue keeps taking one item
// per cycle while it has room, also while the sequencer works.
// A stalled receiver holds the result register; the sequencer waits, and the
// queue fills and then drops item_ready.
// APB register 0 (byte 0): vehicle_id, 7 bits, reset 1.
// Synchronous reset: queue empty, tick count, mode and circle phase zero,
// position and external target at hover (0, 0, -8 m).
module formation_setpoint_generator import fsg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         kind,
  input  logic [7:0]         mode_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         result_kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               last
);

  logic [6:0] vehicle_id;
  fsg_item_t head;
  logic head_valid;
  logic head_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VEHICLE_ID) ? {25'b0, vehicle_id} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_id <= 7'd1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_VEHICLE_ID) begin
      vehicle_id <= pwdata[6:0];
    end
  end

  fsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .mode_value (mode_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  fsg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .vehicle_id   (vehicle_id),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .last         (last)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fsg_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [1:0] rkind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic fin;
  } setpoint_t;

  // Tracks the vehicle's flight state and holds the setpoints still due.
  class formation_tracker;
    logic [6:0] vid;
    logic [15:0] ticks;
    logic [7:0] mode;
    logic [23:0] phase;
    logic signed [31:0] ext[3];
    logic signed [31:0] pos[3];
    setpoint_t due[$];
    int mismatches;

    function new();
      vid = 7'd1;
      ticks = '0;
      mode = '0;
      phase = '0;
      ext[0] = '0; ext[1] = '0; ext[2] = HOVER_Z;
      pos[0] = '0; pos[1] = '0; pos[2] = HOVER_Z;
      mismatches = 0;
    endfunction

    // 4 m * sin(2*pi*k/DEPTH) in Q16.16, k taken from the top bits of the angle
    function logic signed [31:0] circle_coord(logic [23:0] angle);
      logic [63:0] k;
      logic [63:0] q4;
      logic [63:0] quad;
      logic [63:0] rem;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] mag;
      logic signed [31:0] r;
      k = (64'(angle) * 64'(SINE_TABLE_DEPTH)) >> 24;
      q4 = (k % 64'(SINE_TABLE_DEPTH)) * 64'd4;
      quad = q4 / 64'(SINE_TABLE_DEPTH);
      rem = q4 - quad * 64'(SINE_TABLE_DEPTH);
      u = (rem << 30) / 64'(SINE_TABLE_DEPTH);
      if (quad[0]) begin
        u = (64'd1 << 30) - u;
      end
      u2 = (u * u) >> 30;
      p = 64'd172272;
      p = 64'd5026995 - ((u2 * p) >> 30);
      p = 64'd85569306 - ((u2 * p) >> 30);
      p = 64'd693598668 - ((u2 * p) >> 30);
      p = 64'd1686629713 - ((u2 * p) >> 30);
      mag = (((u * p) >> 30) + 64'd2048) >> 12;
      r = mag[31:0];
      return (quad >= 64'd2) ? -r : r;
    endfunction

    function void take_request(fsg_item_t it);
      logic signed [31:0] aim[3];
      logic signed [31:0] span;
      logic signed [31:0] lane_y;
      logic [23:0] heading;
      logic signed [63:0] gap;
      logic [63:0] reach;
      logic [63:0] stride;
      logic cmd_tick;
      setpoint_t sp;
      if (it.kind == KIND_MODE) begin
        mode = it.mode;
      end else if (it.kind == KIND_POINT) begin
        ext[0] = it.px; ext[1] = it.py; ext[2] = it.pz;
      end else if (it.kind == KIND_TICK) begin
        aim[0] = '0; aim[1] = '0; aim[2] = HOVER_Z;
        span = 32'(vid >> 1) << 17;
        lane_y = (vid == 7'd1) ? 32'sd0 : (vid[0] ? -span : span);
        if (ticks > START_TICK) begin
          phase = phase + CIRCLE_STEP;
          if (mode == MODE_CIRCLE) begin
            case ((32'(vid) + 2) % 3)
              1: heading = phase + ONE_THIRD;
              2: heading = phase + TWO_THIRDS;
              default: heading = phase;
            endcase
            aim[0] = circle_coord(heading + QUARTER_TURN);
            aim[1] = circle_coord(heading);
          end else if (mode == MODE_VEE) begin
            aim[0] = (vid == 7'd1) ? 32'sd0 : -span;
            aim[1] = lane_y;
          end else if (mode == MODE_LINE) begin
            aim[1] = lane_y;
          end else if (mode == MODE_EXT) begin
            aim[0] = ext[0]; aim[1] = ext[1]; aim[2] = ext[2];
          end
        end
        // move each axis 5 percent of the way, halves rounded away from zero
        for (int a = 0; a < 3; a++) begin
          gap = aim[a];
          gap = gap - pos[a];
          reach = (gap < 0) ? -gap : gap;
          stride = (reach * 64'(ALPHA_Q16) + 64'd32768) >> 16;
          pos[a] = (gap < 0) ? pos[a] - stride[31:0] : pos[a] + stride[31:0];
        end
        cmd_tick = (ticks == CMD_TICK);
        sp.rkind = RK_SETPOINT;
        sp.x = pos[0]; sp.y = pos[1]; sp.z = pos[2];
        sp.fin = !cmd_tick;
        due.push_back(sp);
        if (ticks != TICK_MAX) begin
          ticks++;
        end
        if (cmd_tick) begin
          sp.x = '0; sp.y = '0; sp.z = '0;
          sp.rkind = RK_OFFBOARD;
          sp.fin = 1'b0;
          due.push_back(sp);
          sp.rkind = RK_ARM;
          sp.fin = 1'b1;
          due.push_back(sp);
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(setpoint_t got);
      setpoint_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result: kind %0d x %h y %h z %h last %b",
                 $time, got.rkind, got.x, got.y, got.z, got.fin);
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare_field("result_kind", 32'(want.rkind), 32'(got.rkind));
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("last", 32'(want.fin), 32'(got.fin));
    endfunction

    function void report_missing();
      if (due.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, due.size());
        mismatches += due.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic item_valid;
  logic item_ready;
  logic [1:0] kind;
  logic [7:0] mode_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic result_valid;
  logic result_ready;
  logic [1:0] result_kind;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic last;

  formation_tracker tracker;
  setpoint_t seen;
  int burst_left = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;
  logic [6:0] vid_plan [6] = '{7'd0, 7'd2, 7'd3, 7'd64, 7'd127, 7'd1};
  logic [7:0] mode_walk [7] = '{MODE_VEE, MODE_LINE, MODE_CIRCLE, MODE_EXT, 8'd0, 8'd5,
                                8'd255};

  always #2 clk = ~clk;

  formation_setpoint_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .mode_value   (mode_value),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .last         (last)
  );

  function automatic fsg_item_t compose(logic [1:0] k, logic [7:0] m, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z);
    fsg_item_t it;
    it.kind = k;
    it.mode = m;
    it.px = x;
    it.py = y;
    it.pz = z;
    return it;
  endfunction

  task automatic write_vehicle_id(logic [6:0] id);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {REG_VEHICLE_ID, 2'b00};
    pwdata = ($urandom() & 32'hFFFF_FF80) | 32'(id);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.vid = pwdata[6:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_item(fsg_item_t it);
    int pause;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        if ($urandom_range(3, 0) != 0) begin
          pause = $urandom_range(8, 1);
          @(negedge clk) item_valid = 1'b0;
          repeat (pause - 1) @(negedge clk);
        end
        burst_left = $urandom_range(12, 1);
      end
      burst_left--;
    end
    @(negedge clk);
    item_valid = 1'b1;
    kind = it.kind;
    mode_value = it.mode;
    point_x = it.px;
    point_y = it.py;
    point_z = it.pz;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tracker.take_request(it);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(compose(KIND_TICK, 8'($urandom()), $urandom(), $urandom(),
                                 $urandom()));
  endtask

  task automatic send_random_item();
    int pick;
    logic [7:0] m;
    logic signed [31:0] c[3];
    pick = $urandom_range(99, 0);
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(3, 0))
        0: c[a] = $urandom();
        1: c[a] = ($urandom_range(1, 0) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        default: c[a] = $signed($urandom_range(40 * 65536, 0)) - 20 * 65536;
      endcase
    end
    if (pick < 55) begin
      send_item(compose(KIND_TICK, 8'($urandom()), c[0], c[1], c[2]));
    end else if (pick < 75) begin
      m = ($urandom_range(9, 0) < 8) ? 8'($urandom_range(4, 1)) : 8'($urandom());
      send_item(compose(KIND_MODE, m, c[0], c[1], c[2]));
    end else if (pick < 93) begin
      send_item(compose(KIND_POINT, 8'($urandom()), c[0], c[1], c[2]));
    end else begin
      send_item(compose(KIND_SPARE, 8'($urandom()), c[0], c[1], c[2]));
    end
  endtask

  // Hold the input low until every expected result is out, then let the
  // sequencer finish any mode or point requests still queued.
  task automatic drain_results();
    @(negedge clk) item_valid = 1'b0;
    burst_left = 0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      seen.rkind = result_kind;
      seen.x = out_x;
      seen.y = out_y;
      seen.z = out_z;
      seen.fin = last;
      tracker.match_result(seen);
    end
  end

  // Receiver: random stall segments, long hold-offs on request, or steady.
  initial begin
    int seg_left;
    int stall_pct;
    seg_left = 0;
    stall_pct = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        result_ready = 1'b0;
        rx_hold--;
      end else if (rx_steady) begin
        result_ready = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(40, 4);
          case ($urandom_range(3, 0))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        result_ready = ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    tracker = new();
    rst = 1'b1;
    item_valid = 1'b0;
    kind = '0;
    mode_value = '0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    write_vehicle_id(7'd1);
    // ignored kind, then a point and a mode that must wait for the start tick
    send_item(compose(KIND_SPARE, 8'hFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF));
    send_item(compose(KIND_POINT, 8'h00, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0));
    send_item(compose(KIND_MODE, MODE_EXT, '0, '0, '0));
    // run through the command tick and past the start tick
    send_ticks(53);
    foreach (mode_walk[i]) begin
      if (mode_walk[i] == MODE_EXT) begin
        send_item(compose(KIND_POINT, 8'h00, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh8000_0000));
      end
      send_item(compose(KIND_MODE, mode_walk[i], '0, '0, '0));
      send_ticks(2);
    end

    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      write_vehicle_id((ph < 6) ? vid_plan[ph] : 7'($urandom_range(126, 4)));
      if (ph == 2) begin
        // stall the receiver while ticks keep coming, so the input backs up
        rx_hold = 80;
        tx_steady = 1'b1;
        send_ticks(16);
        tx_steady = 1'b0;
      end
      repeat (26) send_random_item();
    end

    // run the circle with a steady receiver and back-to-back ticks
    drain_results();
    write_vehicle_id(7'd2);
    send_item(compose(KIND_MODE, MODE_CIRCLE, '0, '0, '0));
    rx_steady = 1'b1;
    tx_steady = 1'b1;
    send_ticks(20);
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    repeat (24) send_random_item();

    @(negedge clk) item_valid = 1'b0;
    for (int w = 0; w < 5000 && tracker.due.size() != 0; w++) @(posedge clk);
    repeat (24) @(posedge clk);
    tracker.report_missing();
    if (tracker.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
